// ----- hdl/urd_pkg.sv -----
// ----------------------------------------------------------------------------
// urd_pkg
// Types, widths, constants and the segment table for the ultrasonic ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package urd_pkg;

   localparam int unsigned TRIG_W  = 10;
   localparam int unsigned DIST_W  = 14;
   localparam int unsigned SEG_W   = 8;
   localparam int unsigned UART_W  = 8;
   localparam int unsigned DIG_W   = 4;
   localparam int unsigned REQ_W   = 8;
   localparam int unsigned RSP_W   = 56;

   localparam logic [TRIG_W-1:0] TRIG_TICKS_RST = 10'd100;
   localparam logic [DIST_W-1:0] DIST_MAX       = 14'd9999;
   localparam logic [DIST_W-1:0] UART_MAX       = 14'd255;

   // reciprocals for the decimal split of a distance up to 9999
   localparam int unsigned PROD_W   = 29;
   localparam logic [14:0] RECIP_10   = 15'd13108;
   localparam int unsigned SH_10      = 17;
   localparam logic [14:0] RECIP_100  = 15'd10486;
   localparam int unsigned SH_100     = 20;
   localparam logic [14:0] RECIP_1000 = 15'd16778;
   localparam int unsigned SH_1000    = 24;

   typedef enum logic [2:0] {
      PH_TRIG  = 3'b001,
      PH_WAIT  = 3'b010,
      PH_COUNT = 3'b100
   } phase_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] dig);
      logic [SEG_W-1:0] seg;
      case (dig)
         4'd0: seg = 8'hBF;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'hFD;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'hFF;
         4'd9: seg = 8'hEF;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ultrasonic_ranger_with_display_top.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranger_with_display_top
// Tick-driven ultrasonic ranging controller with decimal segment and serial
// outputs. Phase control at the input beat, then distance, quotient and
// segment stages.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, set by the phase and counter update at the
// input; each stage holds one beat and stalls only when the next one is full
// reset: phase to trigger, counters and last distance to 0, trigger length
// to 100, pipeline emptied
`default_nettype none

module ultrasonic_ranger_with_display_top
   import urd_pkg::*;
#(
   parameter int unsigned ECHO_COUNT_MAX = 57999
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // csr_data: trigger_ticks[9:0]
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TRIG_W-1:0]   csr_data,
   // req_tdata: echo_level[0], zero padding
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [REQ_W-1:0]    req_tdata,
   // rsp_tdata: trigger_out[0], measure_done[1], distance_cm[15:2],
   // seg_units[23:16], seg_tens[31:24], seg_hundreds[39:32],
   // seg_thousands[47:40], uart_byte[55:48]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata
);

   localparam int unsigned ECW  = $clog2(ECHO_COUNT_MAX + 1);
   localparam int unsigned XW   = ECW + 3;
   localparam int unsigned S29  = ECW + 8;
   localparam int unsigned MW   = ECW + 4;
   localparam int unsigned PW   = XW + MW;
   localparam int unsigned QW   = PW - S29;
   localparam int unsigned QXW  = (QW > DIST_W) ? QW : DIST_W;
   localparam logic [MW-1:0] RECIP_29 = MW'(((64'd1 << S29) + 64'd28) / 64'd29);
   localparam logic [ECW-1:0] ECNT_MAX = ECW'(ECHO_COUNT_MAX);

   // configuration
   logic [TRIG_W-1:0] trig_ticks_ff, trig_ticks_in;

   // controller state
   phase_type         phase_ff, phase_in;
   logic [TRIG_W-1:0] trig_cnt_ff, trig_cnt_in;
   logic [ECW-1:0]    echo_cnt_ff, echo_cnt_in;
   logic [DIST_W-1:0] last_dist_ff, last_dist_in;

   // stage 1
   logic              v1_ff, v1_in;
   logic              s1_trig_ff, s1_trig_in;
   logic              s1_done_ff, s1_done_in;
   logic [ECW-1:0]    s1_cnt_ff, s1_cnt_in;

   // stage 2
   logic              v2_ff, v2_in;
   logic              s2_trig_ff, s2_trig_in;
   logic              s2_done_ff, s2_done_in;
   logic [DIST_W-1:0] s2_dist_ff, s2_dist_in;

   // stage 3
   logic              v3_ff, v3_in;
   logic              s3_trig_ff, s3_trig_in;
   logic              s3_done_ff, s3_done_in;
   logic [DIST_W-1:0] s3_dist_ff, s3_dist_in;
   logic [9:0]        s3_q1_ff, s3_q1_in;
   logic [6:0]        s3_q2_ff, s3_q2_in;
   logic [DIG_W-1:0]  s3_q3_ff, s3_q3_in;

   // output register
   logic              vo_ff, vo_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic rdy_o, rdy3, rdy2, rdy1, req_acc;

   assign rdy_o      = !vo_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy_o;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_acc    = req_tvalid && rdy1;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      trig_ticks_in = trig_ticks_ff;
      if (csr_valid) begin
         trig_ticks_in = csr_data;
      end
   end

   // phase control on each input beat
   logic [TRIG_W-1:0] trig_len, trig_next;
   logic              echo;

   assign echo      = req_tdata[0];
   assign trig_len  = (trig_ticks_ff == '0) ? TRIG_W'(1) : trig_ticks_ff;
   assign trig_next = trig_cnt_ff + TRIG_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      trig_cnt_in = trig_cnt_ff;
      echo_cnt_in = echo_cnt_ff;
      s1_trig_in  = 1'b0;
      s1_done_in  = 1'b0;
      s1_cnt_in   = echo_cnt_ff;
      if (req_acc) begin
         case (phase_ff)
            PH_WAIT: begin
               if (echo) begin
                  echo_cnt_in = ECW'(1);
                  phase_in    = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (echo) begin
                  if (echo_cnt_ff < ECNT_MAX) begin
                     echo_cnt_in = echo_cnt_ff + ECW'(1);
                  end else begin
                     echo_cnt_in = ECNT_MAX;
                  end
               end else begin
                  s1_done_in  = 1'b1;
                  phase_in    = PH_TRIG;
                  trig_cnt_in = '0;
               end
            end
            default: begin
               s1_trig_in  = 1'b1;
               echo_cnt_in = '0;
               if (trig_next >= trig_len) begin
                  trig_cnt_in = '0;
                  phase_in    = PH_WAIT;
               end else begin
                  trig_cnt_in = trig_next;
                  phase_in    = PH_TRIG;
               end
            end
         endcase
      end else begin
         s1_trig_in = s1_trig_ff;
         s1_done_in = s1_done_ff;
         s1_cnt_in  = s1_cnt_ff;
      end
      v1_in = rdy1 ? req_tvalid : v1_ff;
   end

   // distance: floor(count * 5 / 29) by reciprocal
   logic [XW-1:0]     x5;
   logic [PW-1:0]     p29;
   logic [QXW-1:0]    q29;
   logic [DIST_W-1:0] dist_new;

   assign x5  = (XW'(s1_cnt_ff) << 2) + XW'(s1_cnt_ff);
   assign p29 = PW'(x5) * PW'(RECIP_29);
   assign q29 = QXW'(p29[PW-1:S29]);
   assign dist_new = (q29 > QXW'(DIST_MAX)) ? DIST_MAX : DIST_W'(q29);

   always_comb begin
      v2_in        = rdy2 ? v1_ff : v2_ff;
      last_dist_in = last_dist_ff;
      s2_trig_in   = s2_trig_ff;
      s2_done_in   = s2_done_ff;
      s2_dist_in   = s2_dist_ff;
      if (v1_ff && rdy2) begin
         s2_trig_in = s1_trig_ff;
         s2_done_in = s1_done_ff;
         if (s1_done_ff) begin
            last_dist_in = dist_new;
            s2_dist_in   = dist_new;
         end else begin
            s2_dist_in   = last_dist_ff;
         end
      end
   end

   // decimal quotients
   logic [PROD_W-1:0] p10, p100, p1000;

   assign p10   = PROD_W'(s2_dist_ff) * PROD_W'(RECIP_10);
   assign p100  = PROD_W'(s2_dist_ff) * PROD_W'(RECIP_100);
   assign p1000 = PROD_W'(s2_dist_ff) * PROD_W'(RECIP_1000);

   always_comb begin
      v3_in      = rdy3 ? v2_ff : v3_ff;
      s3_trig_in = s3_trig_ff;
      s3_done_in = s3_done_ff;
      s3_dist_in = s3_dist_ff;
      s3_q1_in   = s3_q1_ff;
      s3_q2_in   = s3_q2_ff;
      s3_q3_in   = s3_q3_ff;
      if (v2_ff && rdy3) begin
         s3_trig_in = s2_trig_ff;
         s3_done_in = s2_done_ff;
         s3_dist_in = s2_dist_ff;
         s3_q1_in   = 10'(p10 >> SH_10);
         s3_q2_in   = 7'(p100 >> SH_100);
         s3_q3_in   = DIG_W'(p1000 >> SH_1000);
      end
   end

   // digits, segments and serial byte
   logic [DIST_W-1:0] q1x, q2x, q3x;
   logic [DIG_W-1:0]  dig_u, dig_t, dig_h;
   logic [UART_W-1:0] uart;

   assign q1x   = DIST_W'(s3_q1_ff);
   assign q2x   = DIST_W'(s3_q2_ff);
   assign q3x   = DIST_W'(s3_q3_ff);
   assign dig_u = DIG_W'(s3_dist_ff - (q1x << 3) - (q1x << 1));
   assign dig_t = DIG_W'(q1x - (q2x << 3) - (q2x << 1));
   assign dig_h = DIG_W'(q2x - (q3x << 3) - (q3x << 1));
   assign uart  = (s3_dist_ff > UART_MAX) ? UART_W'(UART_MAX) : UART_W'(s3_dist_ff);

   always_comb begin
      vo_in       = rdy_o ? v3_ff : vo_ff;
      rsp_data_in = rsp_data_ff;
      if (v3_ff && rdy_o) begin
         rsp_data_in = {uart, seg_of(s3_q3_ff), seg_of(dig_h), seg_of(dig_t),
                        seg_of(dig_u), s3_dist_ff, s3_done_ff, s3_trig_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff <= TRIG_TICKS_RST;
         phase_ff      <= PH_TRIG;
         trig_cnt_ff   <= '0;
         echo_cnt_ff   <= '0;
         last_dist_ff  <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         vo_ff         <= 1'b0;
      end else begin
         trig_ticks_ff <= trig_ticks_in;
         phase_ff      <= phase_in;
         trig_cnt_ff   <= trig_cnt_in;
         echo_cnt_ff   <= echo_cnt_in;
         last_dist_ff  <= last_dist_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         vo_ff         <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_trig_ff  <= s1_trig_in;
      s1_done_ff  <= s1_done_in;
      s1_cnt_ff   <= s1_cnt_in;
      s2_trig_ff  <= s2_trig_in;
      s2_done_ff  <= s2_done_in;
      s2_dist_ff  <= s2_dist_in;
      s3_trig_ff  <= s3_trig_in;
      s3_done_ff  <= s3_done_in;
      s3_dist_ff  <= s3_dist_in;
      s3_q1_ff    <= s3_q1_in;
      s3_q2_ff    <= s3_q2_in;
      s3_q3_ff    <= s3_q3_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- hdl/urd_checker.sv -----
// ----------------------------------------------------------------------------
// urd_checker
// Port-level checks for the ultrasonic ranger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urd_checker
   import urd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [RSP_W-1:0]   rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // trigger high and a finished measurement never share a beat
   a_trig_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("trigger and measure done together");

   // distance within display range
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:2] <= DIST_MAX)
      else $error("distance above 9999");

   // serial byte follows the distance
   a_uart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[15:2] > UART_MAX) ? (rsp_tdata[55:48] == 8'hFF)
                                                   : (rsp_tdata[55:48] == rsp_tdata[9:2])))
      else $error("serial byte does not match distance");

endmodule

bind ultrasonic_ranger_with_display_top urd_checker u_urd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- bench/ultrasonic_ranger_with_display_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_ranger_with_display_top_tb
// Self-checking bench for the ultrasonic ranger. Tick beats carry the echo
// level; a model of the trigger, wait and count phases predicts each result
// beat, which is compared field by field in order. A directed table covers
// reset, trigger lengths of zero, one and full scale, echo during trigger,
// the serial byte limit and echo saturation. Random echo pulses follow,
// with bursty input, a choppy receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------

module ultrasonic_ranger_with_display_top_tb;
   import urd_pkg::*;

   localparam int unsigned ECHO_LIMIT = 57999;
   localparam int unsigned RANDOM_BEATS = 800;

   typedef struct packed {
      logic [UART_W-1:0] uart;
      logic [SEG_W-1:0]  seg_k;
      logic [SEG_W-1:0]  seg_h;
      logic [SEG_W-1:0]  seg_t;
      logic [SEG_W-1:0]  seg_u;
      logic [DIST_W-1:0] dist_cm;
      logic              done;
      logic              trig;
   } reading_type;

   typedef enum logic { ROW_BEAT, ROW_CSR } row_kind_type;
   typedef enum logic [1:0] { RX_OPEN, RX_CHOPPY, RX_SPARSE } rx_mode_type;

   typedef struct {
      row_kind_type      kind;
      logic [TRIG_W-1:0] value;
      int                reps;
      bit                typed;
      reading_type       want;
   } dir_row_type;

   localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
      8'hBF, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'hFD, 8'h07, 8'hFF, 8'hEF
   };

   localparam reading_type NO_READING = '0;
   localparam reading_type AFTER_RESET = '{trig: 1'b1, done: 1'b0, dist_cm: 14'd0,
      seg_u: 8'hBF, seg_t: 8'hBF, seg_h: 8'hBF, seg_k: 8'hBF, uart: 8'd0};
   localparam reading_type DONE_ZERO = '{trig: 1'b0, done: 1'b1, dist_cm: 14'd0,
      seg_u: 8'hBF, seg_t: 8'hBF, seg_h: 8'hBF, seg_k: 8'hBF, uart: 8'd0};
   localparam reading_type DONE_255 = '{trig: 1'b0, done: 1'b1, dist_cm: 14'd255,
      seg_u: 8'h6D, seg_t: 8'h6D, seg_h: 8'h5B, seg_k: 8'hBF, uart: 8'd255};
   localparam reading_type DONE_1000 = '{trig: 1'b0, done: 1'b1, dist_cm: 14'd1000,
      seg_u: 8'hBF, seg_t: 8'hBF, seg_h: 8'hBF, seg_k: 8'h06, uart: 8'd255};
   localparam reading_type DONE_SAT = '{trig: 1'b0, done: 1'b1, dist_cm: 14'd9999,
      seg_u: 8'hEF, seg_t: 8'hEF, seg_h: 8'hEF, seg_k: 8'hEF, uart: 8'd255};

   dir_row_type dir_table [23] = '{
      '{ROW_BEAT, 10'd0, 1, 1'b1, AFTER_RESET},
      '{ROW_BEAT, 10'd1, 99, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 3, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1479, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b1, DONE_255},
      '{ROW_CSR, 10'd0, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b1, DONE_ZERO},
      '{ROW_CSR, 10'd1, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 2, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 58200, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b1, DONE_SAT},
      '{ROW_BEAT, 10'd0, 4, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 5800, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b1, DONE_1000},
      '{ROW_CSR, 10'd1023, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1023, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd1, 1485, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b0, NO_READING},
      '{ROW_BEAT, 10'd0, 1, 1'b0, NO_READING}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [TRIG_W-1:0] csr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;

   phase_type         tick_phase;
   logic [TRIG_W-1:0] trig_len;
   logic [TRIG_W-1:0] trig_cnt;
   logic [15:0]       echo_cnt;
   logic [DIST_W-1:0] last_dist;

   reading_type       pending_readings [$];
   int                readings_seen = 0;
   int                beats_sent = 0;
   int                burst_left = 0;
   int                fail_count = 0;

   always #2 clock = ~clock;

   ultrasonic_ranger_with_display_top #(
      .ECHO_COUNT_MAX(ECHO_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic reading_type range_tick(input logic echo);
      reading_type r;
      int unsigned d;
      int unsigned len;
      r = '0;
      case (tick_phase)
         PH_WAIT: begin
            if (echo) begin
               echo_cnt = 16'd1;
               tick_phase = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (echo) begin
               if (echo_cnt < ECHO_LIMIT) echo_cnt = echo_cnt + 16'd1;
               else echo_cnt = ECHO_LIMIT[15:0];
            end else begin
               d = (32'(echo_cnt) * 10) / 58;
               if (d > 9999) d = 9999;
               last_dist = d[DIST_W-1:0];
               r.done = 1'b1;
               tick_phase = PH_TRIG;
               trig_cnt = '0;
            end
         end
         default: begin
            r.trig = 1'b1;
            echo_cnt = '0;
            len = (trig_len == '0) ? 1 : 32'(trig_len);
            trig_cnt = trig_cnt + 10'd1;
            if (32'(trig_cnt) >= len) begin
               trig_cnt = '0;
               tick_phase = PH_WAIT;
            end else begin
               tick_phase = PH_TRIG;
            end
         end
      endcase
      d = 32'(last_dist);
      r.dist_cm = last_dist;
      r.seg_u = DIGIT_SEG[d % 10];
      r.seg_t = DIGIT_SEG[(d / 10) % 10];
      r.seg_h = DIGIT_SEG[(d / 100) % 10];
      r.seg_k = DIGIT_SEG[(d / 1000) % 10];
      r.uart = (d > 255) ? 8'd255 : d[7:0];
      return r;
   endfunction

   task automatic send_tick(input logic echo, input bit typed, input reading_type want);
      int gap;
      reading_type r;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (!req_tvalid) req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-1){1'b0}}, echo};
      do @(posedge clock); while (!req_tready);
      r = range_tick(echo);
      pending_readings.push_back(typed ? want : r);
      beats_sent++;
   endtask

   task automatic write_trigger_len(input logic [TRIG_W-1:0] len);
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      trig_len = len;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = reading_type'(rsp_tdata);
         readings_seen++;
         if (pending_readings.size() == 0) begin
            $error("result beat with no expectation pending");
            fail_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("trigger_out", want.trig, got.trig);
            check_field("measure_done", want.done, got.done);
            check_field("distance_cm", want.dist_cm, got.dist_cm);
            check_field("seg_units", want.seg_u, got.seg_u);
            check_field("seg_tens", want.seg_t, got.seg_t);
            check_field("seg_hundreds", want.seg_h, got.seg_h);
            check_field("seg_thousands", want.seg_k, got.seg_k);
            check_field("uart_byte", want.uart, got.uart);
         end
      end
   end

   // receiver: changing stall pattern, one long hold-off to back up the pipe
   initial begin
      rx_mode_type mode;
      int          left;
      bit          held;
      rsp_tready <= 1'b0;
      mode = RX_OPEN;
      left = 0;
      held = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!held && readings_seen >= 40) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
               RX_CHOPPY: rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
               default:   rsp_tready <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int                i;
      int                k;
      int                n;
      int                random_end;
      logic [TRIG_W-1:0] len;
      tick_phase = PH_TRIG;
      trig_len = TRIG_TICKS_RST;
      trig_cnt = '0;
      echo_cnt = '0;
      last_dist = '0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(dir_table); i++) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_trigger_len(dir_table[i].value);
         end else begin
            for (k = 0; k < dir_table[i].reps; k++)
               send_tick(dir_table[i].value[0], dir_table[i].typed, dir_table[i].want);
         end
      end

      random_end = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_end) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0:       len = '0;
               1:       len = 10'd1;
               2:       len = 10'd1023;
               default: len = 10'($urandom_range(2, 20));
            endcase
            write_trigger_len(len);
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat (12) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_READING);
         end else begin
            // echo noise while the trigger is high
            while (tick_phase == PH_TRIG)
               send_tick(1'($urandom_range(0, 1)), 1'b0, NO_READING);
            repeat ($urandom_range(0, 6)) send_tick(1'b0, 1'b0, NO_READING);
            case ($urandom_range(0, 15))
               0:       n = $urandom_range(1000, 6000);
               1:       n = $urandom_range(60, 999);
               default: n = $urandom_range(1, 80);
            endcase
            repeat (n) send_tick(1'b1, 1'b0, NO_READING);
            send_tick(1'b0, 1'b0, NO_READING);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/urd_pkg.sv
hdl/ultrasonic_ranger_with_display_top.sv
hdl/urd_checker.sv
bench/ultrasonic_ranger_with_display_top_tb.sv
